// File: hw/rtl/region_address_translator_top_defines.svh
// -----------------------------------------------------------------------------
// Region address translator: assertion macros
// Shared concurrent assertion helpers, clocked on i_clk and idle in reset.
// -----------------------------------------------------------------------------
`ifndef REGION_ADDRESS_TRANSLATOR_TOP_DEFINES_SVH
`define REGION_ADDRESS_TRANSLATOR_TOP_DEFINES_SVH

// Generic form with explicit clock and reset.
`define RAT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Usual form on the block clock and reset.
`define RAT_ASSERT(label, prop, msg) \
    `RAT_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// File: hw/rtl/rat_pkg.sv
// -----------------------------------------------------------------------------
// Region address translator package
// Codes and the transaction token that travels along the row of slot cells.
// -----------------------------------------------------------------------------
package rat_pkg;

    // Operation codes carried in the func field.
    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_XLT = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    // One request as it passes from cell to cell.
    typedef struct packed {
        logic        valid;
        logic        func;
        logic [31:0] target_base;
        logic [31:0] local_base;
        logic [31:0] bytes;
        logic [31:0] lookup_addr;
        logic        claimed;
        logic [31:0] local_addr;
    } t_token;

endpackage

// File: hw/rtl/rat_if.sv
// -----------------------------------------------------------------------------
// Region address translator channels
// Valid/ready request and response interfaces with source and sink views.
// -----------------------------------------------------------------------------
interface rat_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] region_target_base;
    logic [31:0] region_local_base;
    logic [31:0] region_bytes;
    logic [31:0] lookup_addr;

    modport source (
        output valid, func, region_target_base, region_local_base, region_bytes,
               lookup_addr,
        input  ready
    );
    modport sink (
        input  valid, func, region_target_base, region_local_base, region_bytes,
               lookup_addr,
        output ready
    );
endinterface

interface rat_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] local_addr;
    logic [31:0] first_region_base;

    modport source (
        output valid, status, local_addr, first_region_base,
        input  ready
    );
    modport sink (
        input  valid, status, local_addr, first_region_base,
        output ready
    );
endinterface

// File: hw/rtl/region_address_translator_top.sv
// -----------------------------------------------------------------------------
// Region address translator top level
// Row of slot cells that adds regions and translates addresses in slot order.
// -----------------------------------------------------------------------------
//  Port       Role      Payload
//  i_req      sink      func, region_target_base, region_local_base,
//                       region_bytes, lookup_addr
//  o_rsp      source    status, local_addr, first_region_base
//
// The first cell registers a transaction at acceptance, it walks the row of
// REGION_SLOTS cells one cell a cycle and then lands in the response register.
// One transaction is in the row at a time; the next is accepted in the cycle
// after the response register loads, even while that response still waits.
// A stalled response freezes the row once the next transaction reaches its
// end. Reset empties every slot at once.
// -----------------------------------------------------------------------------
`include "region_address_translator_top_defines.svh"

module region_address_translator_top
    import rat_pkg::*;
#(
    parameter int REGION_SLOTS = 10
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rat_req_if.sink   i_req,
    rat_rsp_if.source o_rsp
);

    t_token      w_tok [REGION_SLOTS + 1];
    logic [31:0] w_head_base [REGION_SLOTS];
    t_token      w_tail;
    logic        w_accept;
    logic        w_load;
    logic        w_en;

    logic        r_busy;
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_local;
    logic [31:0] r_first;

    // Request side: one transaction in the row at a time.
    assign i_req.ready = !r_busy;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_tok[0] = '{
        valid:       w_accept,
        func:        i_req.func,
        target_base: i_req.region_target_base,
        local_base:  i_req.region_local_base,
        bytes:       i_req.region_bytes,
        lookup_addr: i_req.lookup_addr,
        claimed:     1'b0,
        local_addr:  32'd0
    };

    // The row holds still while a finished transaction cannot leave.
    assign w_tail = w_tok[REGION_SLOTS];
    assign w_load = w_tail.valid && (!r_out_valid || o_rsp.ready);
    assign w_en   = !(w_tail.valid && !w_load);

    // Row of slot cells.
    for (genvar g = 0; g < REGION_SLOTS; g++) begin : g_cell
        rat_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (w_en),
            .i_tok       (w_tok[g]),
            .o_tok       (w_tok[g + 1]),
            .o_head_base (w_head_base[g])
        );
    end

    // Occupancy flag and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload; an unclaimed transaction reports full or no match.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_tail.claimed) begin
                r_status <= ST_OK;
            end else if (w_tail.func == FUNC_XLT) begin
                r_status <= ST_NOMATCH;
            end else begin
                r_status <= ST_FULL;
            end
            r_local <= w_tail.local_addr;
            r_first <= w_head_base[0];
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.status            = r_status;
    assign o_rsp.local_addr        = r_local;
    assign o_rsp.first_region_base = r_first;

    // Checks on the row and the response register.
    `RAT_ASSERT(a_tail_only_when_busy, w_tail.valid |-> r_busy, "token in row while idle")
    `RAT_ASSERT(a_rsp_from_row, $rose(o_rsp.valid) |-> $past(r_busy), "response without a transaction")
    `RAT_ASSERT(a_fail_zero_addr, (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.local_addr == 32'd0), "failed transaction with address")

endmodule

// File: hw/rtl/rat_cell.sv
// -----------------------------------------------------------------------------
// Region address translator slot cell
// Holds one region slot, serves the passing transaction and registers it onward.
// -----------------------------------------------------------------------------
module rat_cell
    import rat_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_token      i_tok,
    output t_token      o_tok,
    output logic [31:0] o_head_base
);

    logic        r_used;
    logic [31:0] r_base;
    logic [32:0] r_end;
    logic [31:0] r_offset;
    t_token      r_tok;

    logic        w_live;
    logic        w_in_range;
    logic        w_hit_add;
    logic        w_hit_xlt;
    t_token      n_tok;

    // The transaction is still looking for a slot.
    assign w_live = i_tok.valid && !i_tok.claimed;

    // The region end is kept in 33 bits so that it never wraps.
    assign w_in_range = r_used
                     && (i_tok.lookup_addr >= r_base)
                     && ({1'b0, i_tok.lookup_addr} < r_end);

    assign w_hit_add = w_live && (i_tok.func == FUNC_ADD) && !r_used;
    assign w_hit_xlt = w_live && (i_tok.func == FUNC_XLT) && w_in_range;

    // A hit claims the transaction so that later cells leave it alone.
    always_comb begin
        n_tok = i_tok;
        if (w_hit_add) begin
            n_tok.claimed = 1'b1;
        end
        if (w_hit_xlt) begin
            n_tok.claimed    = 1'b1;
            n_tok.local_addr = i_tok.lookup_addr + r_offset;
        end
    end

    // Slot storage and the onward token register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= 1'b0;
            r_tok.valid  <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
            if (w_hit_add) begin
                r_used   <= (i_tok.bytes != 32'd0);
                r_base   <= i_tok.target_base;
                r_end    <= {1'b0, i_tok.target_base} + {1'b0, i_tok.bytes};
                r_offset <= i_tok.local_base - i_tok.target_base;
            end
        end
    end

    assign o_tok       = r_tok;
    assign o_head_base = r_used ? r_base : 32'd0;

endmodule

// File: dv/region_address_translator_top_tb.sv
// -----------------------------------------------------------------------------
// Region address translator testbench
// Fills the region table through directed and random add transactions. Then it
// drives translate transactions aimed at region edges, at region interiors and
// at random addresses, under several patterns of sender idling and receiver
// back-pressure. A scoreboard keeps its own copy of the table and checks every
// response, field by field, in order.
// -----------------------------------------------------------------------------
module region_address_translator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rat_pkg::*;

    localparam int SLOTS       = 10;
    localparam int CLK_PERIOD  = 8;
    localparam int PHASE_ITEMS = 295;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        func;
        logic [31:0] target_base;
        logic [31:0] local_base;
        logic [31:0] bytes;
        logic [31:0] lookup_addr;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] local_addr;
        logic [31:0] first_base;
    } t_response;

    // Where a random lookup address is aimed, relative to one stored region.
    typedef enum int {
        AIM_BELOW,
        AIM_START,
        AIM_LAST,
        AIM_PAST,
        AIM_INSIDE,
        AIM_ANYWHERE
    } t_aim;

    // Region table copy and the queue of responses still to arrive.
    class translation_scoreboard;
        logic [31:0] slot_target[SLOTS];
        logic [31:0] slot_local[SLOTS];
        logic [31:0] slot_bytes[SLOTS];
        t_response   awaited[$];
        int          errors;

        function new();
            for (int k = 0; k < SLOTS; k++) begin
                slot_target[k] = '0;
                slot_local[k]  = '0;
                slot_bytes[k]  = '0;
            end
            errors = 0;
        endfunction

        // Applies an accepted request to the table and queues its response.
        function void note_request(t_request rq);
            t_response   rs;
            logic [32:0] span_end;
            bit          done;
            rs   = '0;
            done = 1'b0;
            if (rq.func == FUNC_ADD) begin
                rs.status = ST_FULL;
                for (int k = 0; k < SLOTS; k++) begin
                    if (!done && slot_bytes[k] == '0) begin
                        slot_target[k] = rq.target_base;
                        slot_local[k]  = rq.local_base;
                        slot_bytes[k]  = rq.bytes;
                        rs.status      = ST_OK;
                        done           = 1'b1;
                    end
                end
            end else begin
                rs.status = ST_NOMATCH;
                for (int k = 0; k < SLOTS; k++) begin
                    // The region end is formed in 33 bits so that it cannot wrap.
                    span_end = {1'b0, slot_target[k]} + {1'b0, slot_bytes[k]};
                    if (!done && slot_bytes[k] != '0 && rq.lookup_addr >= slot_target[k]
                            && {1'b0, rq.lookup_addr} < span_end) begin
                        rs.local_addr = slot_local[k] + (rq.lookup_addr - slot_target[k]);
                        rs.status     = ST_OK;
                        done          = 1'b1;
                    end
                end
            end
            rs.first_base = (slot_bytes[0] != '0) ? slot_target[0] : '0;
            awaited.push_back(rs);
        endfunction

        // Compares a response with the oldest outstanding one.
        function void check_response(t_response got);
            t_response want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected response: status %0d local 0x%08h base 0x%08h",
                         $time, got.status, got.local_addr, got.first_base);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.local_addr !== want.local_addr) begin
                $display("%0t: local_addr mismatch: expected 0x%08h, actual 0x%08h",
                         $time, want.local_addr, got.local_addr);
                errors++;
            end
            if (got.first_base !== want.first_base) begin
                $display("%0t: first_region_base mismatch: expected 0x%08h, actual 0x%08h",
                         $time, want.first_base, got.first_base);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   sender_idle_pct;
    int   rsp_stall_pct;
    int   cycle_count = 0;

    translation_scoreboard xlate_sb = new();

    rat_req_if req_if ();
    rat_rsp_if rsp_if ();

    region_address_translator_top #(
        .REGION_SLOTS (SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Clock generation.
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Response back-pressure, decided afresh at every falling edge.
    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Both channels are observed at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                xlate_sb.note_request('{req_if.func, req_if.region_target_base,
                                        req_if.region_local_base, req_if.region_bytes,
                                        req_if.lookup_addr});
            end
            if (rsp_if.valid && rsp_if.ready) begin
                xlate_sb.check_response('{rsp_if.status, rsp_if.local_addr,
                                          rsp_if.first_region_base});
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one transaction from a falling edge and returns at the falling
    // edge after it has been accepted.
    task automatic send_request(input t_request rq);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid              <= 1'b1;
        req_if.func               <= rq.func;
        req_if.region_target_base <= rq.target_base;
        req_if.region_local_base  <= rq.local_base;
        req_if.region_bytes       <= rq.bytes;
        req_if.lookup_addr        <= rq.lookup_addr;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // The unused fields of each operation carry random values.
    task automatic add_region(input logic [31:0] tbase, lbase, nbytes);
        send_request('{FUNC_ADD, tbase, lbase, nbytes, 32'($urandom)});
    endtask

    task automatic translate(input logic [31:0] addr);
        send_request('{FUNC_XLT, 32'($urandom), 32'($urandom), 32'($urandom), addr});
    endtask

    // Picks a lookup address near or inside a random stored region.
    function automatic logic [31:0] pick_address();
        int          k;
        logic [31:0] base;
        logic [31:0] span;
        k    = $urandom_range(SLOTS - 1);
        base = xlate_sb.slot_target[k];
        span = xlate_sb.slot_bytes[k];
        case (t_aim'($urandom_range(AIM_ANYWHERE)))
            AIM_BELOW:  return base - 32'd1;
            AIM_START:  return base;
            AIM_LAST:   return base + span - 32'd1;
            AIM_PAST:   return base + span;
            AIM_INSIDE: return (span == '0) ? base : base + 32'($urandom % span);
            default:    return 32'($urandom);
        endcase
    endfunction

    // Mostly lookups on the full table, with some add transactions that must
    // report a full table, a few of them with zero size.
    task automatic run_random(input int count);
        int roll;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                add_region($urandom, $urandom, (roll < 3) ? 32'd0 : 32'($urandom));
            end else begin
                translate(pick_address());
            end
        end
    endtask

    initial begin
        logic [31:0] nbytes;
        i_rst_n                   = 1'b0;
        req_if.valid              = 1'b0;
        req_if.func               = FUNC_ADD;
        req_if.region_target_base = '0;
        req_if.region_local_base  = '0;
        req_if.region_bytes       = '0;
        req_if.lookup_addr        = '0;
        rsp_if.ready              = 1'b0;
        sender_idle_pct           = 0;
        rsp_stall_pct             = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Lookup on an empty table, then a zero-size add that leaves slot 0 free.
        translate(32'h0000_0000);
        add_region(32'h1234_0000, 32'h0000_dead, 32'd0);
        translate(32'h1234_0000);

        // Region at the very top of the address space, with a wrapping local side.
        add_region(32'hffff_ff00, 32'hffff_fff0, 32'h0000_0200);
        translate(32'hffff_feff);
        translate(32'hffff_ff00);
        translate(32'hffff_ffff);

        // One-byte region, then an overlapping one in a later slot.
        add_region(32'h0000_1000, 32'h0000_0000, 32'd1);
        translate(32'h0000_1000);
        translate(32'h0000_1001);
        add_region(32'h0000_0f00, 32'h5000_0000, 32'h0000_0200);
        translate(32'h0000_1000);
        translate(32'h0000_10ff);
        translate(32'h0000_1100);

        // Largest size: the region end goes past 32 bits.
        add_region(32'h8000_0000, 32'h4000_0000, 32'hffff_ffff);
        translate(32'hffff_ff80);
        translate(32'h8000_0000);
        translate(32'h7fff_ffff);

        // Fill the remaining slots with regions of mixed scale, then overflow.
        for (int k = 4; k < SLOTS; k++) begin
            case (k % 3)
                0:       nbytes = $urandom_range(1, 16);
                1:       nbytes = $urandom_range(1, 65536);
                default: nbytes = ($urandom >> $urandom_range(31)) | 32'd1;
            endcase
            add_region($urandom, $urandom, nbytes);
        end
        add_region(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

        // Random traffic under each idling pattern in turn.
        run_random(PHASE_ITEMS);
        sender_idle_pct = 78;
        run_random(PHASE_ITEMS);
        sender_idle_pct = 0;
        rsp_stall_pct   = 78;
        run_random(PHASE_ITEMS);
        sender_idle_pct = 21;
        rsp_stall_pct   = 21;
        run_random(PHASE_ITEMS);
        req_if.valid <= 1'b0;

        // Drain, then allow for any stray response.
        while (xlate_sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 4) @(posedge i_clk);
        if (xlate_sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
